[rtl/core/sil_pkg.sv]
// ----------------------------------------------------------------------------
// sil_pkg
// Types and codes shared by the sorted insert list block and its interfaces.
// ----------------------------------------------------------------------------
package sil_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LIST   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ENTRY = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_LST_RD,
        S_LST_OUT,
        S_RESP
    } t_state;

    localparam int KEY_W = 8;
    localparam int TAG_W = 8;
    localparam int POS_W = 5;

endpackage

[rtl/core/sil_in_if.sv]
// ----------------------------------------------------------------------------
// sil_in_if
// Request channel: operation kind, entity tag and signed key.
// ----------------------------------------------------------------------------
interface sil_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [sil_pkg::TAG_W-1:0]         entity_id;
    logic signed [sil_pkg::KEY_W-1:0]  initiative;

    modport source (output valid, output kind, output entity_id, output initiative,
                    input ready);
    modport sink   (input valid, input kind, input entity_id, input initiative,
                    output ready);
endinterface

[rtl/core/sil_out_if.sv]
// ----------------------------------------------------------------------------
// sil_out_if
// Result channel: status, rank, entry tag and key, last marker.
// ----------------------------------------------------------------------------
interface sil_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [sil_pkg::POS_W-1:0]         position;
    logic [sil_pkg::TAG_W-1:0]         out_entity_id;
    logic signed [sil_pkg::KEY_W-1:0]  out_initiative;
    logic                              last;

    modport source (output valid, output status, output position, output out_entity_id,
                    output out_initiative, output last, input ready);
    modport sink   (input valid, input status, input position, input out_entity_id,
                    input out_initiative, input last, output ready);
endinterface

[rtl/core/sorted_insert_list.sv]
// ----------------------------------------------------------------------------
// sorted_insert_list
// Bounded list of entity tags kept in descending order of a signed key.
// ----------------------------------------------------------------------------
// Entries live in one RAM (key and tag side by side) with a registered read
// port, walked by a small sequencer that reuses a single signed comparator.
// An insert scans from the tail toward the head, moving each entry with a
// lower key down one slot, and drops the new entry in behind the first one
// whose key is greater or equal (equal keys keep arrival order). A full list
// answers with a full status and stores nothing. A list request emits one
// transaction per entry, each read from the RAM and then loaded into the
// output register, as the RAM has a single registered read port; an empty
// list answers with an empty status. Clear empties the list and emits
// nothing; an unused kind code is consumed silently. The input is not ready
// while a request is being worked on. The output register lets the last
// result wait while the next request is taken.
// ----------------------------------------------------------------------------
module sorted_insert_list #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sil_in_if.sink    i_in,
    sil_out_if.source o_out
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = sil_pkg::KEY_W;
    localparam int TW    = sil_pkg::TAG_W;
    localparam int PW    = sil_pkg::POS_W;
    localparam int RW    = KW + TW;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    sil_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic [TW-1:0]    r_tag, n_tag;
    logic signed [KW-1:0] r_key, n_key;
    sil_pkg::t_status r_status, n_status;

    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_status, n_out_status;
    logic [PW-1:0]    r_out_pos, n_out_pos;
    logic [TW-1:0]    r_out_tag, n_out_tag;
    logic [KW-1:0]    r_out_key, n_out_key;
    logic             r_out_last, n_out_last;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [RW-1:0]    ram_rdata;

    logic             slot_free;
    logic             in_fire;
    logic [CW-1:0]    idx_inc;
    logic signed [KW-1:0] rd_key;

    sil_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free = !r_out_valid || o_out.ready;
    assign in_fire   = i_in.valid && (r_state == sil_pkg::S_IDLE);
    assign idx_inc   = CW'(r_idx) + CW'(1);
    assign rd_key    = $signed(ram_rdata[RW-1:TW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sil_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_tag        <= n_tag;
        r_key        <= n_key;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_tag    <= n_out_tag;
        r_out_key    <= n_out_key;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_tag        = r_tag;
        n_key        = r_key;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_tag    = r_out_tag;
        n_out_key    = r_out_key;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = {r_key, r_tag};
        ram_raddr    = r_idx;

        case (r_state)
            sil_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_tag = i_in.entity_id;
                    n_key = i_in.initiative;
                    case (i_in.kind)
                        sil_pkg::KIND_INSERT: begin
                            if (r_count == FULL_COUNT) begin
                                n_status = sil_pkg::ST_FULL;
                                n_state  = sil_pkg::S_RESP;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = sil_pkg::S_INS_PUT;
                            end else begin
                                n_idx   = AW'(r_count - CW'(1));
                                n_state = sil_pkg::S_INS_RD;
                            end
                        end
                        sil_pkg::KIND_LIST: begin
                            if (r_count == '0) begin
                                n_status = sil_pkg::ST_EMPTY;
                                n_state  = sil_pkg::S_RESP;
                            end else begin
                                n_idx   = '0;
                                n_state = sil_pkg::S_LST_RD;
                            end
                        end
                        sil_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            sil_pkg::S_INS_RD: begin
                n_state = sil_pkg::S_INS_CMP;
            end

            sil_pkg::S_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_inc);
                if (rd_key < r_key) begin
                    // stored entry ranks below the new one: move it down a slot
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = sil_pkg::S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = sil_pkg::S_INS_RD;
                    end
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = sil_pkg::ST_OK;
                    n_state  = sil_pkg::S_RESP;
                end
            end

            sil_pkg::S_INS_PUT: begin
                ram_we   = 1'b1;
                n_count  = r_count + CW'(1);
                n_status = sil_pkg::ST_OK;
                n_state  = sil_pkg::S_RESP;
            end

            sil_pkg::S_LST_RD: begin
                n_state = sil_pkg::S_LST_OUT;
            end

            sil_pkg::S_LST_OUT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = sil_pkg::ST_ENTRY;
                    n_out_pos    = PW'(idx_inc);
                    n_out_tag    = ram_rdata[TW-1:0];
                    n_out_key    = ram_rdata[RW-1:TW];
                    n_out_last   = (idx_inc == r_count);
                    if (idx_inc == r_count) begin
                        n_state = sil_pkg::S_IDLE;
                    end else begin
                        n_idx   = AW'(idx_inc);
                        n_state = sil_pkg::S_LST_RD;
                    end
                end
            end

            sil_pkg::S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = '0;
                    n_out_tag    = '0;
                    n_out_key    = '0;
                    n_out_last   = 1'b1;
                    n_state      = sil_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sil_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready           = (r_state == sil_pkg::S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.position       = r_out_pos;
    assign o_out.out_entity_id  = r_out_tag;
    assign o_out.out_initiative = r_out_key;
    assign o_out.last           = r_out_last;

endmodule

[rtl/core/sil_ram.sv]
// ----------------------------------------------------------------------------
// sil_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
